[hdl/i2c_rrs_pkg.sv]
package i2c_rrs_pkg;

    // Direction bit appended to the seven-bit device address.
    localparam logic DIR_BIT_WR = 1'b0;
    localparam logic DIR_BIT_RD = 1'b1;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WSTART = 4'd1,
        PH_WADDR  = 4'd2,
        PH_WDATA  = 4'd3,
        PH_WSTOP  = 4'd4,
        PH_RSTART = 4'd5,
        PH_RADDR  = 4'd6,
        PH_RDATA  = 4'd7,
        PH_RSTOP  = 4'd8
    } phase_t;

    // Commands to the byte engine.
    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_START      = 4'd1,
        ACT_ADDR_WRITE = 4'd2,
        ACT_SEND_BYTE  = 4'd3,
        ACT_STOP       = 4'd4,
        ACT_ADDR_READ  = 4'd5,
        ACT_ACK_OFF    = 4'd6,
        ACT_TAKE_BYTES = 4'd7,
        ACT_CLEAR_POS  = 4'd8
    } action_t;

    // Read status codes.
    typedef enum logic [1:0] {
        ST_NOT_YET   = 2'd0,
        ST_DONE      = 2'd1,
        ST_ACK_FAIL  = 2'd2,
        ST_BUS_ERROR = 2'd3
    } status_t;

    // Operation codes of an input transfer.
    typedef enum logic {
        OP_POLL  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    // One input transfer.
    typedef struct packed {
        logic       opcode;
        logic [6:0] device_address;
        logic [7:0] register_index;
        logic       start_sent_flag;
        logic       address_done_flag;
        logic       tx_empty_flag;
        logic       byte_done_flag;
        logic       bus_busy_flag;
        logic       ack_fail_flag;
        logic       bus_error_flag;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  out_byte;
        logic        clear_ack_fail;
        logic        clear_bus_error;
        logic [1:0]  status;
        logic        done_pulse;
        logic [15:0] read_value;
        logic        idle;
        logic        ack_fail_seen;
        logic        bus_error_seen;
    } out_item_t;

    // Architectural state of the sequencer.
    typedef struct packed {
        phase_t      phase;
        logic [6:0]  target_address;
        logic [7:0]  target_register;
        logic [15:0] captured_value;
        logic [15:0] delivered_value;
        status_t     status_code;
        logic        ack_fail_sticky;
        logic        bus_error_sticky;
    } seq_state_t;

endpackage

[hdl/i2c_rrs_step.sv]
module i2c_rrs_step (
    input  i2c_rrs_pkg::seq_state_t state_cur,
    input  i2c_rrs_pkg::in_item_t   item,
    output i2c_rrs_pkg::seq_state_t state_new,
    output i2c_rrs_pkg::out_item_t  result
);

    i2c_rrs_pkg::action_t action;
    logic [7:0]           obyte;
    logic                 err_phase;
    logic                 clr_af;
    logic                 clr_be;
    logic                 done;

    // Phase transition for one transfer, then error handling in address and data phases.
    always_comb begin
        state_new = state_cur;
        action    = i2c_rrs_pkg::ACT_NONE;
        obyte     = 8'd0;
        err_phase = 1'b0;
        clr_af    = 1'b0;
        clr_be    = 1'b0;
        done      = 1'b0;

        if (item.opcode == i2c_rrs_pkg::OP_START) begin
            state_new.target_address  = item.device_address;
            state_new.target_register = item.register_index;
            state_new.captured_value  = 16'd0;
            state_new.delivered_value = 16'd0;
            state_new.status_code     = i2c_rrs_pkg::ST_NOT_YET;
            state_new.phase           = i2c_rrs_pkg::PH_WSTART;
            action                    = i2c_rrs_pkg::ACT_START;
        end else begin
            case (state_cur.phase)
                i2c_rrs_pkg::PH_WSTART: begin
                    if (item.start_sent_flag) begin
                        action          = i2c_rrs_pkg::ACT_ADDR_WRITE;
                        obyte           = {state_cur.target_address, i2c_rrs_pkg::DIR_BIT_WR};
                        state_new.phase = i2c_rrs_pkg::PH_WADDR;
                    end
                end
                i2c_rrs_pkg::PH_WADDR: begin
                    err_phase = 1'b1;
                    if (item.address_done_flag) begin
                        action          = i2c_rrs_pkg::ACT_SEND_BYTE;
                        obyte           = state_cur.target_register;
                        state_new.phase = i2c_rrs_pkg::PH_WDATA;
                    end
                end
                i2c_rrs_pkg::PH_WDATA: begin
                    err_phase = 1'b1;
                    if (item.tx_empty_flag || item.byte_done_flag) begin
                        action          = i2c_rrs_pkg::ACT_STOP;
                        state_new.phase = i2c_rrs_pkg::PH_WSTOP;
                    end
                end
                i2c_rrs_pkg::PH_WSTOP: begin
                    if (!item.bus_busy_flag) begin
                        action          = i2c_rrs_pkg::ACT_START;
                        state_new.phase = i2c_rrs_pkg::PH_RSTART;
                    end
                end
                i2c_rrs_pkg::PH_RSTART: begin
                    if (item.start_sent_flag) begin
                        action          = i2c_rrs_pkg::ACT_ADDR_READ;
                        obyte           = {state_cur.target_address, i2c_rrs_pkg::DIR_BIT_RD};
                        state_new.phase = i2c_rrs_pkg::PH_RADDR;
                    end
                end
                i2c_rrs_pkg::PH_RADDR: begin
                    err_phase = 1'b1;
                    if (item.address_done_flag) begin
                        action          = i2c_rrs_pkg::ACT_ACK_OFF;
                        state_new.phase = i2c_rrs_pkg::PH_RDATA;
                    end
                end
                i2c_rrs_pkg::PH_RDATA: begin
                    err_phase = 1'b1;
                    if (item.byte_done_flag) begin
                        action                   = i2c_rrs_pkg::ACT_TAKE_BYTES;
                        state_new.captured_value = {item.first_byte, item.second_byte};
                        state_new.phase          = i2c_rrs_pkg::PH_RSTOP;
                    end
                end
                i2c_rrs_pkg::PH_RSTOP: begin
                    if (!item.bus_busy_flag) begin
                        action                    = i2c_rrs_pkg::ACT_CLEAR_POS;
                        state_new.delivered_value = state_cur.captured_value;
                        state_new.status_code     = i2c_rrs_pkg::ST_DONE;
                        done                      = 1'b1;
                        state_new.phase           = i2c_rrs_pkg::PH_IDLE;
                    end
                end
                default: begin
                    // Idle, or a phase code with no meaning: rest in idle.
                    state_new.phase = i2c_rrs_pkg::PH_IDLE;
                end
            endcase

            // A bus error is applied after an ack failure so that its status wins.
            if (err_phase) begin
                if (item.ack_fail_flag) begin
                    clr_af                    = 1'b1;
                    state_new.status_code     = i2c_rrs_pkg::ST_ACK_FAIL;
                    state_new.ack_fail_sticky = 1'b1;
                    done                      = 1'b1;
                    state_new.phase           = i2c_rrs_pkg::PH_IDLE;
                end
                if (item.bus_error_flag) begin
                    clr_be                     = 1'b1;
                    state_new.status_code      = i2c_rrs_pkg::ST_BUS_ERROR;
                    state_new.bus_error_sticky = 1'b1;
                    done                       = 1'b1;
                    state_new.phase            = i2c_rrs_pkg::PH_IDLE;
                end
            end
        end
    end

    // Result fields reflect the state after this transfer.
    always_comb begin
        result.action          = action;
        result.out_byte        = obyte;
        result.clear_ack_fail  = clr_af;
        result.clear_bus_error = clr_be;
        result.status          = state_new.status_code;
        result.done_pulse      = done;
        result.read_value      = state_new.delivered_value;
        result.idle            = (state_new.phase == i2c_rrs_pkg::PH_IDLE);
        result.ack_fail_seen   = state_new.ack_fail_sticky;
        result.bus_error_seen  = state_new.bus_error_sticky;
    end

endmodule

[hdl/i2c_register_read_sequencer_unit.sv]
// Two-byte register read sequencer for an I2C byte engine. Each input transfer is
// either a start request or a poll carrying the engine flags and received bytes,
// and each one yields exactly one result transfer with the next engine command.
// The block takes one transfer per clock while the result side does not stall: an
// input register feeds the phase step logic, whose command and updated state are
// captured together into the result register, which holds the result until the
// consumer takes it; a full input register is freed only as the result register is
// loaded. The input side keeps taking transfers while a finished result waits for
// the consumer, holding at most one more.
module i2c_register_read_sequencer_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  i2c_rrs_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output i2c_rrs_pkg::out_item_t m_data
);

    logic                    in_valid_reg;
    i2c_rrs_pkg::in_item_t   in_item_reg;
    logic                    out_valid_reg;
    i2c_rrs_pkg::out_item_t  out_item_reg;
    i2c_rrs_pkg::seq_state_t state_reg;
    i2c_rrs_pkg::seq_state_t state_next;
    i2c_rrs_pkg::out_item_t  result_next;
    logic                    advance;

    // An item moves to the result register when that register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    i2c_rrs_step u_step (
        .state_cur (state_reg),
        .item      (in_item_reg),
        .state_new (state_next),
        .result    (result_next)
    );

    // Control state: stage valids and the sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            state_reg.phase            <= i2c_rrs_pkg::PH_IDLE;
            state_reg.target_address   <= 7'd0;
            state_reg.target_register  <= 8'd0;
            state_reg.captured_value   <= 16'd0;
            state_reg.delivered_value  <= 16'd0;
            state_reg.status_code      <= i2c_rrs_pkg::ST_NOT_YET;
            state_reg.ack_fail_sticky  <= 1'b0;
            state_reg.bus_error_sticky <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

[bench/i2c_rrs_checker.sv]
// Watches both channels of the register read sequencer, predicts the command
// returned for every accepted input transfer and compares it with the result
// transfers in order.
module i2c_rrs_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  i2c_rrs_pkg::in_item_t  s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  i2c_rrs_pkg::out_item_t m_data,
    output int                     mismatch_count,
    output int                     commands_pending
);

    localparam int REPORT_LIMIT = 10;

    // Predicted copy of the sequencer state.
    i2c_rrs_pkg::phase_t  seq_phase;
    logic [6:0]           dev_addr;
    logic [7:0]           reg_idx;
    logic [15:0]          rx_value;
    logic [15:0]          value_out;
    i2c_rrs_pkg::status_t read_status;
    logic                 af_sticky;
    logic                 be_sticky;

    // Commands predicted for accepted inputs, oldest first.
    i2c_rrs_pkg::out_item_t predicted_commands[$];

    // Advance the predicted state by one input transfer and return the command.
    task automatic step_sequencer(input i2c_rrs_pkg::in_item_t it,
                                  output i2c_rrs_pkg::out_item_t res);
        logic err_window;
        res = '0;
        err_window = 1'b0;
        if (it.opcode == i2c_rrs_pkg::OP_START) begin
            dev_addr    = it.device_address;
            reg_idx     = it.register_index;
            rx_value    = '0;
            value_out   = '0;
            read_status = i2c_rrs_pkg::ST_NOT_YET;
            seq_phase   = i2c_rrs_pkg::PH_WSTART;
            res.action  = i2c_rrs_pkg::ACT_START;
        end else begin
            case (seq_phase)
                i2c_rrs_pkg::PH_WSTART: begin
                    if (it.start_sent_flag) begin
                        res.action   = i2c_rrs_pkg::ACT_ADDR_WRITE;
                        res.out_byte = {dev_addr, i2c_rrs_pkg::DIR_BIT_WR};
                        seq_phase    = i2c_rrs_pkg::PH_WADDR;
                    end
                end
                i2c_rrs_pkg::PH_WADDR: begin
                    err_window = 1'b1;
                    if (it.address_done_flag) begin
                        res.action   = i2c_rrs_pkg::ACT_SEND_BYTE;
                        res.out_byte = reg_idx;
                        seq_phase    = i2c_rrs_pkg::PH_WDATA;
                    end
                end
                i2c_rrs_pkg::PH_WDATA: begin
                    err_window = 1'b1;
                    if (it.tx_empty_flag || it.byte_done_flag) begin
                        res.action = i2c_rrs_pkg::ACT_STOP;
                        seq_phase  = i2c_rrs_pkg::PH_WSTOP;
                    end
                end
                i2c_rrs_pkg::PH_WSTOP: begin
                    if (!it.bus_busy_flag) begin
                        res.action = i2c_rrs_pkg::ACT_START;
                        seq_phase  = i2c_rrs_pkg::PH_RSTART;
                    end
                end
                i2c_rrs_pkg::PH_RSTART: begin
                    if (it.start_sent_flag) begin
                        res.action   = i2c_rrs_pkg::ACT_ADDR_READ;
                        res.out_byte = {dev_addr, i2c_rrs_pkg::DIR_BIT_RD};
                        seq_phase    = i2c_rrs_pkg::PH_RADDR;
                    end
                end
                i2c_rrs_pkg::PH_RADDR: begin
                    err_window = 1'b1;
                    if (it.address_done_flag) begin
                        res.action = i2c_rrs_pkg::ACT_ACK_OFF;
                        seq_phase  = i2c_rrs_pkg::PH_RDATA;
                    end
                end
                i2c_rrs_pkg::PH_RDATA: begin
                    err_window = 1'b1;
                    if (it.byte_done_flag) begin
                        res.action = i2c_rrs_pkg::ACT_TAKE_BYTES;
                        rx_value   = {it.first_byte, it.second_byte};
                        seq_phase  = i2c_rrs_pkg::PH_RSTOP;
                    end
                end
                i2c_rrs_pkg::PH_RSTOP: begin
                    if (!it.bus_busy_flag) begin
                        res.action     = i2c_rrs_pkg::ACT_CLEAR_POS;
                        value_out      = rx_value;
                        read_status    = i2c_rrs_pkg::ST_DONE;
                        res.done_pulse = 1'b1;
                        seq_phase      = i2c_rrs_pkg::PH_IDLE;
                    end
                end
                default: begin
                    seq_phase = i2c_rrs_pkg::PH_IDLE;
                end
            endcase

            // Errors end the read only in address and data phases; bus error wins.
            if (err_window && it.ack_fail_flag) begin
                res.clear_ack_fail = 1'b1;
                read_status        = i2c_rrs_pkg::ST_ACK_FAIL;
                af_sticky          = 1'b1;
                res.done_pulse     = 1'b1;
                seq_phase          = i2c_rrs_pkg::PH_IDLE;
            end
            if (err_window && it.bus_error_flag) begin
                res.clear_bus_error = 1'b1;
                read_status         = i2c_rrs_pkg::ST_BUS_ERROR;
                be_sticky           = 1'b1;
                res.done_pulse      = 1'b1;
                seq_phase           = i2c_rrs_pkg::PH_IDLE;
            end
        end
        res.status         = read_status;
        res.read_value     = value_out;
        res.idle           = (seq_phase == i2c_rrs_pkg::PH_IDLE);
        res.ack_fail_seen  = af_sticky;
        res.bus_error_seen = be_sticky;
    endtask

    // Predict on input transfers and compare on result transfers.
    always @(posedge aclk) begin : monitor
        i2c_rrs_pkg::out_item_t want;
        i2c_rrs_pkg::out_item_t got;
        if (!aresetn) begin
            seq_phase      = i2c_rrs_pkg::PH_IDLE;
            dev_addr       = '0;
            reg_idx        = '0;
            rx_value       = '0;
            value_out      = '0;
            read_status    = i2c_rrs_pkg::ST_NOT_YET;
            af_sticky      = 1'b0;
            be_sticky      = 1'b0;
            mismatch_count = 0;
            predicted_commands.delete();
        end else begin
            if (s_valid && s_ready) begin
                step_sequencer(s_data, want);
                predicted_commands.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (predicted_commands.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result transfer with no command predicted: %h", got);
                end else begin
                    want = predicted_commands.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("result mismatch: expected %h, got %h", want, got);
                    end
                end
            end
        end
        commands_pending = predicted_commands.size();
    end

endmodule

[bench/tb_i2c_register_read_sequencer_unit.sv]
// Drives start and poll transfers into the register read sequencer, stalls the
// result side at random and reports the verdict of the checker.
module tb_i2c_register_read_sequencer_unit;

    localparam int TOTAL_TRANSFERS = 1520;
    localparam int CALM_AFTER      = 1300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 20;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    i2c_rrs_pkg::in_item_t  s_data;
    logic                   m_valid;
    logic                   m_ready;
    i2c_rrs_pkg::out_item_t m_data;

    int mismatch_count;
    int commands_pending;
    int transfers_sent;
    int quiet_cycles;
    bit calm;

    i2c_register_read_sequencer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    i2c_rrs_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .mismatch_count   (mismatch_count),
        .commands_pending (commands_pending)
    );

    // Clock with a period of 10.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random stall bursts, none in the final part of the run.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing is transferred for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_i2c_register_read_sequencer_unit failed");
            $finish;
        end
    end

    function automatic i2c_rrs_pkg::in_item_t random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(i2c_rrs_pkg::in_item_t)-1:0];
    endfunction

    // A poll aimed at one phase: advance sets the flag that moves it on, otherwise
    // the flags hold it in place. errs gives {bus error, ack failure}.
    function automatic i2c_rrs_pkg::in_item_t make_poll(i2c_rrs_pkg::phase_t ph,
                                                        bit advance, logic [1:0] errs);
        i2c_rrs_pkg::in_item_t it;
        it = random_item();
        it.opcode = i2c_rrs_pkg::OP_POLL;
        {it.bus_error_flag, it.ack_fail_flag} = errs;
        case (ph)
            i2c_rrs_pkg::PH_WSTART, i2c_rrs_pkg::PH_RSTART: it.start_sent_flag = advance;
            i2c_rrs_pkg::PH_WADDR, i2c_rrs_pkg::PH_RADDR:   it.address_done_flag = advance;
            i2c_rrs_pkg::PH_WDATA: begin
                if (advance)
                    {it.tx_empty_flag, it.byte_done_flag} = 2'($urandom_range(1, 3));
                else
                    {it.tx_empty_flag, it.byte_done_flag} = 2'b00;
            end
            i2c_rrs_pkg::PH_WSTOP, i2c_rrs_pkg::PH_RSTOP:   it.bus_busy_flag = !advance;
            i2c_rrs_pkg::PH_RDATA:                          it.byte_done_flag = advance;
            default: ;
        endcase
        return it;
    endfunction

    // Present one transfer, with an occasional gap ahead of it, and wait for it
    // to be taken.
    task automatic send_item(input i2c_rrs_pkg::in_item_t it);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        transfers_sent++;
        calm = (transfers_sent >= CALM_AFTER);
    endtask

    // One register read with random hold polls; it may be abandoned early or
    // ended by an injected error in an address or data phase.
    task automatic run_read();
        i2c_rrs_pkg::in_item_t it;
        i2c_rrs_pkg::phase_t   ph;
        logic [1:0]            errs;
        bit                    err_window;
        int                    holds;
        it = random_item();
        it.opcode = i2c_rrs_pkg::OP_START;
        send_item(it);
        for (int p = i2c_rrs_pkg::PH_WSTART; p <= i2c_rrs_pkg::PH_RSTOP; p++) begin
            ph = i2c_rrs_pkg::phase_t'(p);
            err_window = (ph == i2c_rrs_pkg::PH_WADDR) || (ph == i2c_rrs_pkg::PH_WDATA) ||
                         (ph == i2c_rrs_pkg::PH_RADDR) || (ph == i2c_rrs_pkg::PH_RDATA);
            // Leaving now lets the next start arrive while this read is busy.
            if ($urandom_range(0, 29) == 0)
                return;
            holds = $urandom_range(0, 2);
            for (int k = 0; k <= holds; k++) begin
                if (!err_window)
                    errs = 2'($urandom_range(0, 3));
                else if ($urandom_range(0, 19) == 0)
                    errs = 2'($urandom_range(1, 3));
                else
                    errs = 2'b00;
                send_item(make_poll(ph, k == holds, errs));
                if (err_window && errs != 2'b00)
                    return;
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        i2c_rrs_pkg::in_item_t it;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        transfers_sent = 0;
        calm           = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Poll while idle with every flag set.
        it = '1;
        it.opcode = i2c_rrs_pkg::OP_POLL;
        send_item(it);

        // Clean read at the top address and register with all-ones bytes.
        it = '1;
        send_item(it);
        for (int p = i2c_rrs_pkg::PH_WSTART; p <= i2c_rrs_pkg::PH_RSTOP; p++) begin
            it = make_poll(i2c_rrs_pkg::phase_t'(p), 1'b1, 2'b00);
            it.first_byte  = 8'hFF;
            it.second_byte = 8'hFF;
            send_item(it);
        end

        // Address zero; progress and both errors together in the address phase.
        it = '0;
        it.opcode = i2c_rrs_pkg::OP_START;
        send_item(it);
        send_item(make_poll(i2c_rrs_pkg::PH_WSTART, 1'b1, 2'b00));
        send_item(make_poll(i2c_rrs_pkg::PH_WADDR, 1'b1, 2'b11));

        // Errors ignored outside address and data phases, then an ack failure alone.
        it = '0;
        it.opcode = i2c_rrs_pkg::OP_START;
        send_item(it);
        send_item(make_poll(i2c_rrs_pkg::PH_WSTART, 1'b0, 2'b11));
        send_item(make_poll(i2c_rrs_pkg::PH_WSTART, 1'b1, 2'b00));
        send_item(make_poll(i2c_rrs_pkg::PH_WADDR, 1'b0, 2'b01));

        // Start while busy, then a bus error alone in the write data phase.
        it = random_item();
        it.opcode = i2c_rrs_pkg::OP_START;
        send_item(it);
        send_item(it);
        send_item(make_poll(i2c_rrs_pkg::PH_WSTART, 1'b1, 2'b00));
        send_item(make_poll(i2c_rrs_pkg::PH_WADDR, 1'b1, 2'b00));
        send_item(make_poll(i2c_rrs_pkg::PH_WDATA, 1'b0, 2'b10));

        // Mostly well-formed reads, with bursts of arbitrary transfers.
        while (transfers_sent < TOTAL_TRANSFERS) begin
            if ($urandom_range(0, 99) < 85) begin
                run_read();
            end else begin
                repeat ($urandom_range(1, 4)) send_item(random_item());
            end
        end
        s_valid <= 1'b0;

        // Let every predicted command arrive, then allow for the pipeline depth.
        while (commands_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("tb_i2c_register_read_sequencer_unit passed");
        else
            $display("tb_i2c_register_read_sequencer_unit failed");
        $finish;
    end

endmodule

[files.f]
hdl/i2c_rrs_pkg.sv
hdl/i2c_rrs_step.sv
hdl/i2c_register_read_sequencer_unit.sv
bench/i2c_rrs_checker.sv
bench/tb_i2c_register_read_sequencer_unit.sv
